@@ rtl/core/itoa_pkg.sv @@
package itoa_pkg;

    // Width of the signed input value
    localparam int VALUE_WIDTH = 32;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;

    // BCD digit adjust threshold for shift-and-add-3
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    // Decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
    function automatic int max_digits(input int width);
        longint unsigned val;
        int              n;
        val = longint'(1) << (width - 1);
        n   = 1;
        while (val >= 64'd10) begin
            val = val / 64'd10;
            n   = n + 1;
        end
        return n;
    endfunction

    localparam int NUM_DIGITS = max_digits(VALUE_WIDTH);
    localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic shift;
        logic find;
        logic emit_sign;
        logic emit_digit;
    } itoa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic conv_last;
        logic neg;
        logic idx_zero;
    } itoa_status_t;

endpackage

@@ rtl/core/int_to_decimal_ascii.sv @@
// Before the first character, an item passes through the load, the 32 shift-and-add-3
// steps of the BCD converter and the leading-digit search.
// A run holds 1 to 11 characters; a new item is accepted only while the controller is idle;
// characters leave back to back, one per cycle, and the receiver cannot stall.
// Reset: rst_n clears the controller to idle and drops valid; no item in flight survives.
module int_to_decimal_ascii
    import itoa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   valid,
    output logic [7:0]             character,
    output logic                   last
);

    itoa_cmd_t    cmd;
    itoa_status_t status;

    // Sequencer
    itoa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Magnitude, BCD conversion and character output
    itoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .status    (status),
        .valid     (valid),
        .character (character),
        .last      (last)
    );

    // An accepted item keeps the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transfer");

    // A run has no gaps between its characters
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |=> valid)
        else $error("gap inside a character run");

    // Conversion time separates runs
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("character right after end of run");

    // Only the final character may leave once the controller is idle
    a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> busy)
        else $error("run character while idle");

endmodule

@@ rtl/core/itoa_ctrl.sv @@
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  itoa_status_t status,
    output itoa_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_FIND  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.conv_last)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = status.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = S_DIGIT;
            end
            S_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.idx_zero)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/core/itoa_dp.sv @@
module itoa_dp
    import itoa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  itoa_cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0] value,
    output itoa_status_t           status,
    output logic                   valid,
    output logic [7:0]             character,
    output logic                   last
);

    logic [VALUE_WIDTH-1:0]           mag_reg;
    logic [VALUE_WIDTH-1:0]           mag_next;
    logic                             neg_reg;
    logic                             neg_next;
    logic [NUM_DIGITS-1:0][3:0]       bcd_reg;
    logic [NUM_DIGITS-1:0][3:0]       bcd_next;
    logic [NUM_DIGITS-1:0][3:0]       bcd_adj;
    logic [NUM_DIGITS*4-1:0]          bcd_adj_flat;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [CNT_W-1:0]                 cnt_next;
    logic [IDX_W-1:0]                 idx_reg;
    logic [IDX_W-1:0]                 idx_next;
    logic [IDX_W-1:0]                 idx_top;
    logic                             valid_reg;
    logic                             valid_next;
    logic [7:0]                       char_reg;
    logic [7:0]                       char_next;
    logic                             last_reg;
    logic                             last_next;
    logic [VALUE_WIDTH-1:0]           mag_load;
    logic [3:0]                       cur_digit;

    // Magnitude of the two's complement input; the most negative value wraps exactly
    assign mag_load = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

    // Add-3 correction on each BCD digit ahead of the shift
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            bcd_adj[d] = (bcd_reg[d] >= BCD_ADJ_MIN) ? (bcd_reg[d] + BCD_ADJ_ADD) : bcd_reg[d];
        end
    end

    assign bcd_adj_flat = bcd_adj;

    // Highest nonzero digit, zero when the value is zero
    always_comb
    begin
        idx_top = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d] != 4'd0)
            begin
                idx_top = IDX_W'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg];

    // Datapath next values
    always_comb
    begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cmd.load)
        begin
            mag_next = mag_load;
            neg_next = value[VALUE_WIDTH-1];
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_WIDTH);
        end
        if (cmd.shift)
        begin
            // Top digit never exceeds its range, so its high bit drops out
            bcd_next = {bcd_adj_flat[NUM_DIGITS*4-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.find)
        begin
            idx_next = idx_top;
        end
        if (cmd.emit_sign)
        begin
            valid_next = 1'b1;
            char_next  = CH_MINUS;
            last_next  = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            valid_next = 1'b1;
            char_next  = CH_ZERO + {4'd0, cur_digit};
            last_next  = (idx_reg == '0);
            idx_next   = idx_reg - IDX_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        bcd_reg  <= bcd_next[NUM_DIGITS-1:0];
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.conv_last = (cnt_reg == CNT_W'(1));
    assign status.neg       = neg_reg;
    assign status.idx_zero  = (idx_reg == '0);

    assign valid     = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule
